// ===== hw/rtl/fnvb_pkg.sv =====
// shared constants and types for the fnv1a bucket index block
`timescale 1ns / 1ps

package fnvb_pkg;

  localparam int INDEX_BITS = 17;
  localparam int COUNT_W    = INDEX_BITS + 1;
  localparam int HASH_W     = 64;
  localparam int BYTE_W     = 8;

  localparam logic [HASH_W-1:0]  FNV_BASIS   = 64'hCBF29CE484222325;
  // fnv prime is 2^40 + 0x1b3
  localparam int                 FNV_SHIFT   = 40;
  localparam logic [8:0]         FNV_LO      = 9'h1B3;
  localparam logic [HASH_W-1:0]  GOLDEN_MUL  = 64'h9E3779B97F4A7C15;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1) << INDEX_BITS;

  typedef struct packed {
    logic              vld;
    logic [HASH_W-1:0] hash;
  } hash_xfer_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL0,
    BK_MUL1,
    BK_MUL2,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

// ===== hw/rtl/fnvb_front.sv =====
// front end: takes key bytes and folds them into the running fnv-1a hash
`timescale 1ns / 1ps

module fnvb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fnvb_pkg::BYTE_W-1:0]   in_key_byte,
  input  logic                          in_last_byte,
  input  logic                          q_full,
  output fnvb_pkg::hash_xfer_t          push
);

  logic [fnvb_pkg::HASH_W-1:0] hash_r;
  logic [fnvb_pkg::HASH_W-1:0] hash_nxt;
  logic [fnvb_pkg::HASH_W-1:0] hash_x;
  logic                        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    hash_x   = hash_r ^ {{(fnvb_pkg::HASH_W-fnvb_pkg::BYTE_W){1'b0}}, in_key_byte};
    // multiply by 2^40 + 0x1b3, modulo 2^64
    hash_nxt = (hash_x << fnvb_pkg::FNV_SHIFT)
             + (hash_x * fnvb_pkg::HASH_W'(fnvb_pkg::FNV_LO));
  end

  assign push.vld  = accept && in_last_byte;
  assign push.hash = hash_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= fnvb_pkg::FNV_BASIS;
    end else if (accept) begin
      hash_r <= in_last_byte ? fnvb_pkg::FNV_BASIS : hash_nxt;
    end
  end

endmodule

// ===== hw/rtl/fnvb_queue.sv =====
// two-entry queue of finished key hashes between front and back end
`timescale 1ns / 1ps

module fnvb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fnvb_pkg::hash_xfer_t push,
  input  logic                 pop,
  output logic                 full,
  output fnvb_pkg::hash_xfer_t head
);

  logic [fnvb_pkg::HASH_W-1:0] mem_r [2];
  logic                        wr_ptr_r;
  logic                        rd_ptr_r;
  logic [1:0]                  cnt_r;
  logic                        do_pop;

  assign full      = (cnt_r == 2'd2);
  assign head.vld  = (cnt_r != 2'd0);
  assign head.hash = mem_r[rd_ptr_r];
  assign do_pop    = pop && head.vld;

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push.vld) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push.vld, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fnvb_back.sv =====
// back end: golden-ratio multiply, then top-bit select or bit-serial modulo
`timescale 1ns / 1ps

module fnvb_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [fnvb_pkg::COUNT_W-1:0]   bucket_count,
  input  fnvb_pkg::hash_xfer_t           head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fnvb_pkg::INDEX_BITS-1:0] out_bucket_index,
  output logic [fnvb_pkg::HASH_W-1:0]    out_key_hash
);

  localparam int HALF_W = fnvb_pkg::HASH_W / 2;
  localparam int K_W    = $clog2(fnvb_pkg::COUNT_W);
  localparam int SH_W   = $clog2(fnvb_pkg::HASH_W) + 1;
  localparam int DIV_W  = $clog2(fnvb_pkg::HASH_W);

  fnvb_pkg::back_state_t state_r;
  fnvb_pkg::back_state_t state_nxt;

  logic [fnvb_pkg::HASH_W-1:0]     hash_r;
  logic [fnvb_pkg::HASH_W-1:0]     prod_r;
  logic [fnvb_pkg::COUNT_W-1:0]    rem_r;
  logic [DIV_W-1:0]                cnt_r;
  logic                            out_valid_r;
  logic [fnvb_pkg::INDEX_BITS-1:0] out_idx_r;
  logic [fnvb_pkg::HASH_W-1:0]     out_hash_r;

  logic [fnvb_pkg::COUNT_W-1:0]    eff_cnt;
  logic                            is_pow2;
  logic [K_W-1:0]                  log2_k;
  logic [HALF_W-1:0]               mul_a;
  logic [HALF_W-1:0]               mul_b;
  logic [fnvb_pkg::HASH_W-1:0]     mul_p;
  logic [fnvb_pkg::COUNT_W:0]      rem_sh;
  logic [fnvb_pkg::COUNT_W-1:0]    rem_nxt;
  logic [fnvb_pkg::HASH_W-1:0]     top_bits;
  logic [fnvb_pkg::INDEX_BITS-1:0] idx_val;
  logic                            out_free;
  logic                            load_out;

  // zero acts as one, anything above the index range saturates
  always_comb begin
    if (bucket_count == '0) begin
      eff_cnt = fnvb_pkg::COUNT_W'(1);
    end else if (bucket_count > fnvb_pkg::COUNT_LIMIT) begin
      eff_cnt = fnvb_pkg::COUNT_LIMIT;
    end else begin
      eff_cnt = bucket_count;
    end
    is_pow2 = ((eff_cnt & (eff_cnt - fnvb_pkg::COUNT_W'(1))) == '0);
    log2_k  = '0;
    for (int i = 0; i < fnvb_pkg::COUNT_W; i++) begin
      if (eff_cnt[i]) begin
        log2_k = K_W'(i);
      end
    end
  end

  // one shared 32x32 multiplier, three partial products in BK_MUL0, BK_MUL1, BK_MUL2
  always_comb begin
    case (state_r)
      fnvb_pkg::BK_MUL0: begin
        mul_a = hash_r[HALF_W-1:0];
        mul_b = fnvb_pkg::GOLDEN_MUL[HALF_W-1:0];
      end
      fnvb_pkg::BK_MUL1: begin
        mul_a = hash_r[HALF_W-1:0];
        mul_b = fnvb_pkg::GOLDEN_MUL[fnvb_pkg::HASH_W-1:HALF_W];
      end
      default: begin
        mul_a = hash_r[fnvb_pkg::HASH_W-1:HALF_W];
        mul_b = fnvb_pkg::GOLDEN_MUL[HALF_W-1:0];
      end
    endcase
    mul_p = fnvb_pkg::HASH_W'(mul_a) * fnvb_pkg::HASH_W'(mul_b);
  end

  // restoring division step, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r, prod_r[fnvb_pkg::HASH_W-1]};
    if (rem_sh >= {1'b0, eff_cnt}) begin
      rem_nxt = fnvb_pkg::COUNT_W'(rem_sh - {1'b0, eff_cnt});
    end else begin
      rem_nxt = rem_sh[fnvb_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    top_bits = prod_r >> (SH_W'(fnvb_pkg::HASH_W) - SH_W'(log2_k));
    if (!is_pow2) begin
      idx_val = rem_r[fnvb_pkg::INDEX_BITS-1:0];
    end else if (log2_k == '0) begin
      idx_val = '0;
    end else begin
      idx_val = top_bits[fnvb_pkg::INDEX_BITS-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fnvb_pkg::BK_IDLE: begin
        if (head.vld) begin
          state_nxt = fnvb_pkg::BK_MUL0;
        end
      end
      fnvb_pkg::BK_MUL0: state_nxt = fnvb_pkg::BK_MUL1;
      fnvb_pkg::BK_MUL1: state_nxt = fnvb_pkg::BK_MUL2;
      fnvb_pkg::BK_MUL2: begin
        state_nxt = is_pow2 ? fnvb_pkg::BK_DONE : fnvb_pkg::BK_DIV;
      end
      fnvb_pkg::BK_DIV: begin
        if (cnt_r == '1) begin
          state_nxt = fnvb_pkg::BK_DONE;
        end
      end
      fnvb_pkg::BK_DONE: begin
        if (out_free) begin
          state_nxt = fnvb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = fnvb_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      fnvb_pkg::BK_IDLE: pop      = head.vld;
      fnvb_pkg::BK_DONE: load_out = out_free;
      default: begin
        pop      = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fnvb_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hash_r <= head.hash;
    end
    case (state_r)
      fnvb_pkg::BK_MUL0: prod_r <= mul_p;
      fnvb_pkg::BK_MUL1, fnvb_pkg::BK_MUL2: begin
        prod_r[fnvb_pkg::HASH_W-1:HALF_W] <= prod_r[fnvb_pkg::HASH_W-1:HALF_W]
                                           + mul_p[HALF_W-1:0];
        rem_r <= '0;
        cnt_r <= '0;
      end
      fnvb_pkg::BK_DIV: begin
        prod_r <= prod_r << 1;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r + DIV_W'(1);
      end
      default: begin
        prod_r <= prod_r;
      end
    endcase
    if (load_out) begin
      out_idx_r  <= idx_val;
      out_hash_r <= hash_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bucket_index = out_idx_r;
  assign out_key_hash     = out_hash_r;

endmodule

// ===== hw/rtl/fnv1a_bucket_index.sv =====
// top level: fnv-1a key hash with multiplicative bucket index
// path: the hash of a key's last byte goes through the queue to the back end,
//   which runs a three-step 32x32 multiply, then a 64-step bit-serial modulo
//   unless the bucket count is a power of two; it takes no new key until done
// throughput: one key byte per cycle into the hash while the queue is not full
// reset: synchronous active low; hash re-seeds, queue empties, bucket count is 8
`timescale 1ns / 1ps

module fnv1a_bucket_index (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fnvb_pkg::COUNT_W-1:0]    cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fnvb_pkg::BYTE_W-1:0]     in_key_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fnvb_pkg::INDEX_BITS-1:0] out_bucket_index,
  output logic [fnvb_pkg::HASH_W-1:0]     out_key_hash
);

  logic [fnvb_pkg::COUNT_W-1:0] bucket_count_r;
  fnvb_pkg::hash_xfer_t         push;
  fnvb_pkg::hash_xfer_t         head;
  logic                         q_full;
  logic                         pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= fnvb_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      bucket_count_r <= cfg_wr_data;
    end
  end

  fnvb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .push         (push)
  );

  fnvb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  fnvb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .bucket_count     (bucket_count_r),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket_index (out_bucket_index),
    .out_key_hash     (out_key_hash)
  );

endmodule

// ===== hw/rtl/fnvb_checker.sv =====
// port-level checker for the bucket index block, bound to the top level
`timescale 1ns / 1ps

module fnvb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_wr_en,
  input logic [fnvb_pkg::COUNT_W-1:0]    cfg_wr_data,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [fnvb_pkg::INDEX_BITS-1:0] out_bucket_index,
  input logic [fnvb_pkg::HASH_W-1:0]     out_key_hash
);

  logic [fnvb_pkg::COUNT_W-1:0] count_r;

  // shadow of the bucket count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= fnvb_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bucket_index)
                               && $stable(out_key_hash))
    else $error("result transaction changed while stalled");

  a_out_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_in_reset: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_one_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (count_r == '0 || count_r == fnvb_pkg::COUNT_W'(1))
      |-> out_bucket_index == '0)
    else $error("nonzero index with a single bucket");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && count_r != '0 && count_r <= fnvb_pkg::COUNT_LIMIT
      |-> {1'b0, out_bucket_index} < count_r)
    else $error("bucket index beyond bucket count");

endmodule

bind fnv1a_bucket_index fnvb_checker u_fnvb_checker (.*);

// ===== tb/fnv1a_bucket_index_test.sv =====
// self-checking testbench for the fnv1a bucket index block
`timescale 1ns / 1ps

module fnv1a_bucket_index_test;

  localparam logic [fnvb_pkg::HASH_W-1:0] FNV_PRIME = 64'h100000001B3;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASES       = 10;
  localparam int PHASE_BYTES  = 40;

  typedef struct packed {
    logic [fnvb_pkg::INDEX_BITS-1:0] index;
    logic [fnvb_pkg::HASH_W-1:0]     hash;
  } bucket_result_t;

  typedef struct packed {
    logic [fnvb_pkg::COUNT_W-1:0]    cnt;
    logic [fnvb_pkg::BYTE_W-1:0]     kb;
    logic                            lb;
    logic                            fixed;
    logic [fnvb_pkg::INDEX_BITS-1:0] idx;
  } dir_row_t;

  localparam int DIR_ROWS = 19;

  // bucket count, key byte, last flag, index known by inspection, that index
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{18'd8,      8'h00, 1'b1, 1'b0, 17'd0},
    '{18'd8,      8'hFF, 1'b1, 1'b0, 17'd0},
    '{18'd8,      8'h61, 1'b0, 1'b0, 17'd0},
    '{18'd8,      8'h62, 1'b0, 1'b0, 17'd0},
    '{18'd8,      8'h63, 1'b1, 1'b0, 17'd0},
    '{18'd1,      8'h5A, 1'b1, 1'b1, 17'd0},
    '{18'd1,      8'h00, 1'b0, 1'b0, 17'd0},
    '{18'd1,      8'hFF, 1'b1, 1'b1, 17'd0},
    '{18'd0,      8'hA5, 1'b1, 1'b1, 17'd0},
    '{18'd131072, 8'hFF, 1'b1, 1'b0, 17'd0},
    '{18'd131072, 8'h00, 1'b1, 1'b0, 17'd0},
    '{18'd262143, 8'h80, 1'b1, 1'b0, 17'd0},
    '{18'd262143, 8'h7F, 1'b0, 1'b0, 17'd0},
    '{18'd262143, 8'h01, 1'b1, 1'b0, 17'd0},
    '{18'd131071, 8'h01, 1'b1, 1'b0, 17'd0},
    '{18'd131071, 8'hFE, 1'b1, 1'b0, 17'd0},
    '{18'd3,      8'h55, 1'b1, 1'b0, 17'd0},
    '{18'd2,      8'hAA, 1'b1, 1'b0, 17'd0},
    '{18'd7,      8'h3C, 1'b1, 1'b0, 17'd0}
  };

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [fnvb_pkg::COUNT_W-1:0]    cfg_wr_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [fnvb_pkg::BYTE_W-1:0]     in_key_byte;
  logic                            in_last_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic [fnvb_pkg::INDEX_BITS-1:0] out_bucket_index;
  logic [fnvb_pkg::HASH_W-1:0]     out_key_hash;

  // typed-in index travels with the transaction it belongs to
  logic                            fix_en;
  logic [fnvb_pkg::INDEX_BITS-1:0] fix_idx;

  logic [fnvb_pkg::HASH_W-1:0]     hash_acc = fnvb_pkg::FNV_BASIS;
  logic [fnvb_pkg::COUNT_W-1:0]    bucket_cnt = fnvb_pkg::COUNT_RESET;
  bucket_result_t                  bucket_results_q [$];
  int                              errors = 0;
  int                              cycle_cnt = 0;
  bit                              quiet = 1'b0;
  bit                              hold_long = 1'b0;

  fnv1a_bucket_index u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_byte      (in_key_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket_index (out_bucket_index),
    .out_key_hash     (out_key_hash)
  );

  always #10 clk = ~clk;

  // fibonacci multiply, then top bits for a power of two or modulo otherwise
  function automatic logic [fnvb_pkg::INDEX_BITS-1:0] bucket_of(
      input logic [fnvb_pkg::HASH_W-1:0]  h,
      input logic [fnvb_pkg::COUNT_W-1:0] cnt);
    logic [fnvb_pkg::HASH_W-1:0] c;
    logic [fnvb_pkg::HASH_W-1:0] prod;
    logic [fnvb_pkg::HASH_W-1:0] r;
    int k;
    c = fnvb_pkg::HASH_W'(cnt);
    if (c == 0) c = 1;
    if (c > fnvb_pkg::HASH_W'(fnvb_pkg::COUNT_LIMIT)) begin
      c = fnvb_pkg::HASH_W'(fnvb_pkg::COUNT_LIMIT);
    end
    prod = h * fnvb_pkg::GOLDEN_MUL;
    if ((c & (c - 1)) == 0) begin
      k = 0;
      while ((c >> k) != 1) k++;
      r = (k == 0) ? '0 : prod >> (fnvb_pkg::HASH_W - k);
    end else begin
      r = prod % c;
    end
    return r[fnvb_pkg::INDEX_BITS-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int key_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 16);
    return $urandom_range(17, 64);
  endfunction

  function automatic logic [fnvb_pkg::COUNT_W-1:0] random_count();
    case ($urandom_range(0, 2))
      0: return fnvb_pkg::COUNT_W'(1) << $urandom_range(0, fnvb_pkg::INDEX_BITS);
      1: return fnvb_pkg::COUNT_W'($urandom_range(1, 131072));
      default: return fnvb_pkg::COUNT_W'($urandom_range(0, 262143));
    endcase
  endfunction

  task automatic send_byte(input logic [fnvb_pkg::BYTE_W-1:0] kb, input logic lb,
                           input logic fixed,
                           input logic [fnvb_pkg::INDEX_BITS-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_key_byte  <= kb;
    in_last_byte <= lb;
    fix_en       <= fixed;
    fix_idx      <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_key(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(fnvb_pkg::BYTE_W'($urandom_range(0, 255)), i == len - 1, 1'b0, '0);
    end
  endtask

  // let the clock advance first so the last accepted transaction is already predicted
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bucket_results_q.size() != 0) @(posedge clk);
  endtask

  // bucket count only changes with the block idle, hash stage included
  task automatic write_count(input logic [fnvb_pkg::COUNT_W-1:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    bucket_cnt = value;
  endtask

  always @(posedge clk) begin : track
    bucket_result_t r;
    bucket_result_t e;
    if (rst_n && in_valid && !in_stall) begin
      hash_acc = (hash_acc ^ fnvb_pkg::HASH_W'(in_key_byte)) * FNV_PRIME;
      if (in_last_byte) begin
        r.index = fix_en ? fix_idx : bucket_of(hash_acc, bucket_cnt);
        r.hash  = hash_acc;
        bucket_results_q.push_back(r);
        hash_acc = fnvb_pkg::FNV_BASIS;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (bucket_results_q.size() == 0) begin
        $error("unexpected result: bucket_index %0d key_hash %h",
               out_bucket_index, out_key_hash);
        errors++;
      end else begin
        e = bucket_results_q.pop_front();
        if (out_bucket_index !== e.index) begin
          $error("bucket_index: expected %0d, actual %0d", e.index, out_bucket_index);
          errors++;
        end
        if (out_key_hash !== e.hash) begin
          $error("key_hash: expected %h, actual %h", e.hash, out_key_hash);
          errors++;
        end
      end
    end
  end

  // result side back-pressure, plus one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** fnv1a_bucket_index: FAILED **");
    $finish;
  end

  initial begin
    logic [fnvb_pkg::COUNT_W-1:0] c;
    int sent;
    int len;
    bit paused;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_key_byte  = '0;
    in_last_byte = 1'b0;
    fix_en       = 1'b0;
    fix_idx      = '0;
    paused       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first rows run on the reset bucket count
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cnt != bucket_cnt) write_count(dir_rows[i].cnt);
      send_byte(dir_rows[i].kb, dir_rows[i].lb, dir_rows[i].fixed, dir_rows[i].idx);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: c = fnvb_pkg::COUNT_LIMIT;
        1: c = fnvb_pkg::COUNT_W'(1);
        2: c = '1;
        3: c = fnvb_pkg::COUNT_W'(5);
        default: c = random_count();
      endcase
      write_count(c);
      quiet = (ph == 2);
      // short keys pile results into the back end while the output is held
      if (ph == 4) hold_long = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        len = (ph == 4) ? $urandom_range(1, 2) : key_len();
        send_key(len);
        sent += len;
        if (ph == 6 && sent >= PHASE_BYTES / 2 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      quiet = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** fnv1a_bucket_index: PASSED **");
    end else begin
      $display("** fnv1a_bucket_index: FAILED **");
    end
    $finish;
  end

endmodule

// ===== fnv1a_bucket_index.f =====
hw/rtl/fnvb_pkg.sv
hw/rtl/fnvb_front.sv
hw/rtl/fnvb_queue.sv
hw/rtl/fnvb_back.sv
hw/rtl/fnv1a_bucket_index.sv
hw/rtl/fnvb_checker.sv
tb/fnv1a_bucket_index_test.sv
